### rtl/multichannel_adc_oversample_averager_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the oversampling averager
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_ADC_OVERSAMPLE_AVERAGER_MACROS_SVH
`define MULTICHANNEL_ADC_OVERSAMPLE_AVERAGER_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising edge outside reset.
`define MCAOA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Property that must never hold outside reset.
`define MCAOA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MCAOA_ASSERT(lbl, prop, msg)
`define MCAOA_NEVER(lbl, expr, msg)
`endif

`endif

### rtl/mcaoa_pkg.sv
// ----------------------------------------------------------------------------
// mcaoa_pkg
// Shared widths, limits, register indexes, state type and bank control type.
// ----------------------------------------------------------------------------
package mcaoa_pkg;

	localparam int SLOT_W     = 4;
	localparam int SAMPLE_W   = 12;
	localparam int SUM_W      = 22;
	localparam int CNT_W      = 11;
	localparam int CC_W       = 5;
	localparam int AVG_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int STEP_W     = 5;
	localparam int CHANNELS   = 16;

	localparam logic [CC_W-1:0]   CH_LIMIT   = 5'd16;
	localparam logic [CNT_W-1:0]  SMP_LIMIT  = 11'd1024;
	localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [AVG_W-1:0]  AVG_MAX    = {AVG_W{1'b1}};
	localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(SUM_W - 1);

	localparam logic [CC_W-1:0]  CC_RESET  = 5'd1;
	localparam logic [CNT_W-1:0] SPA_RESET = 11'd16;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_AVERAGE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                acc_en;
		logic                clear_all;
		logic [SLOT_W-1:0]   addr;
		logic [SAMPLE_W-1:0] sample;
	} bank_ctl_t;

endpackage

### rtl/mcaoa_sum_bank.sv
// ----------------------------------------------------------------------------
// mcaoa_sum_bank
// Per-slot saturating accumulators with one read-modify-write port and a
// clear that zeroes every slot at once.
// ----------------------------------------------------------------------------
module mcaoa_sum_bank (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mcaoa_pkg::bank_ctl_t                   ctl,
	output logic [mcaoa_pkg::SUM_W-1:0]            rd_sum
);

	logic [mcaoa_pkg::SUM_W-1:0] sums_q [mcaoa_pkg::CHANNELS];
	logic [mcaoa_pkg::SUM_W:0]   add_wide;
	logic [mcaoa_pkg::SUM_W-1:0] add_sat;

	assign rd_sum   = sums_q[ctl.addr];
	assign add_wide = {1'b0, rd_sum} + (mcaoa_pkg::SUM_W + 1)'(ctl.sample);
	assign add_sat  = add_wide[mcaoa_pkg::SUM_W] ? mcaoa_pkg::SUM_MAX
	                                             : add_wide[mcaoa_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcaoa_pkg::CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else if (ctl.clear_all) begin
			for (int i = 0; i < mcaoa_pkg::CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else if (ctl.acc_en) begin
			sums_q[ctl.addr] <= add_sat;
		end
	end

endmodule

### rtl/mcaoa_div.sv
// ----------------------------------------------------------------------------
// mcaoa_div
// Restoring divider, one quotient bit per cycle, shared by every slot.
// ----------------------------------------------------------------------------
module mcaoa_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mcaoa_pkg::SUM_W-1:0]     dividend,
	input  logic [mcaoa_pkg::CNT_W-1:0]     divisor,
	output logic                            done,
	output logic [mcaoa_pkg::SUM_W-1:0]     quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [mcaoa_pkg::STEP_W-1:0]  step_q;
	logic [mcaoa_pkg::SUM_W-1:0]   quo_q;
	logic [mcaoa_pkg::CNT_W-1:0]   rem_q;
	logic [mcaoa_pkg::CNT_W-1:0]   divisor_q;
	logic [mcaoa_pkg::CNT_W:0]     trial;
	logic [mcaoa_pkg::CNT_W:0]     diff;
	logic                          ge;

	// The quotient bits shift in from the bottom as the dividend bits leave the top.
	assign trial = {rem_q, quo_q[mcaoa_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == mcaoa_pkg::STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mcaoa_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? diff[mcaoa_pkg::CNT_W-1:0] : trial[mcaoa_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/multichannel_adc_oversample_averager.sv
// Accumulation: an item is accepted in the idle state and folded into its slot on the
// next cycle if the slot is below the channel count; no new conversion result is taken until then.
// A sweep that completes the average stalls input while each slot in turn runs through
// the shared 22-step restoring divider and then waits for its result to be taken.
// Reset (arst_n low, asynchronous): accumulators and sweep count clear, channel_count
// returns to 1 and samples_per_average to 16, no result is pending.
// ----------------------------------------------------------------------------
// multichannel_adc_oversample_averager
// Per-slot oversampling accumulators with a sequenced divide and emit walk.
// ----------------------------------------------------------------------------
`include "multichannel_adc_oversample_averager_macros.svh"

module multichannel_adc_oversample_averager (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,   // [3:0] slot, [15:4] sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [15:0]                          m_tdata,   // [3:0] out_slot, [13:4] average_value, [15:14] zero
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mcaoa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcaoa_pkg::CNT_W-1:0]          cfg_data
);

	mcaoa_pkg::state_t state_q, state_d;
	mcaoa_pkg::bank_ctl_t bank_ctl;

	logic [mcaoa_pkg::CC_W-1:0]     cc_q;
	logic [mcaoa_pkg::CNT_W-1:0]    spa_q;
	logic [mcaoa_pkg::CNT_W-1:0]    sweep_q;
	logic [mcaoa_pkg::SLOT_W-1:0]   idx_q;
	logic [mcaoa_pkg::SLOT_W-1:0]   slot_q;
	logic [mcaoa_pkg::SAMPLE_W-1:0] sample_q;
	logic [mcaoa_pkg::SLOT_W-1:0]   out_slot_q;
	logic [mcaoa_pkg::AVG_W-1:0]    avg_q;
	logic                           last_q;

	logic [mcaoa_pkg::CC_W-1:0]     nch;
	logic [mcaoa_pkg::CC_W-1:0]     nch_m1;
	logic [mcaoa_pkg::CNT_W-1:0]    ns;
	logic [mcaoa_pkg::CNT_W-1:0]    sweep_inc;
	logic                           in_range;
	logic                           sweep_end;
	logic                           fire;
	logic                           div_start;
	logic                           div_done;
	logic [mcaoa_pkg::SUM_W-1:0]    rd_sum;
	logic [mcaoa_pkg::SUM_W-1:0]    quotient;
	logic [mcaoa_pkg::SUM_W-3:0]    q_shift;
	logic                           s_xfer;
	logic                           m_xfer;
	logic                           cfg_xfer;

	assign nch    = (cc_q > mcaoa_pkg::CH_LIMIT) ? mcaoa_pkg::CH_LIMIT : cc_q;
	assign nch_m1 = nch - 1'b1;
	assign ns     = (spa_q == '0) ? mcaoa_pkg::CNT_W'(1)
	              : (spa_q > mcaoa_pkg::SMP_LIMIT) ? mcaoa_pkg::SMP_LIMIT : spa_q;

	assign in_range  = {1'b0, slot_q} < nch;
	assign sweep_end = in_range && ({1'b0, slot_q} == nch_m1);
	assign sweep_inc = sweep_q + 1'b1;
	assign fire      = sweep_end && (sweep_inc >= ns);

	assign s_xfer   = s_tvalid && s_tready;
	assign m_xfer   = m_tvalid && m_tready;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mcaoa_pkg::ST_IDLE: begin
				if (s_xfer) state_d = mcaoa_pkg::ST_ACC;
			end
			mcaoa_pkg::ST_ACC: begin
				state_d = fire ? mcaoa_pkg::ST_DIV_GO : mcaoa_pkg::ST_IDLE;
			end
			mcaoa_pkg::ST_DIV_GO: begin
				state_d = mcaoa_pkg::ST_DIV_WAIT;
			end
			mcaoa_pkg::ST_DIV_WAIT: begin
				if (div_done) state_d = mcaoa_pkg::ST_EMIT;
			end
			mcaoa_pkg::ST_EMIT: begin
				if (m_tready) state_d = last_q ? mcaoa_pkg::ST_IDLE : mcaoa_pkg::ST_DIV_GO;
			end
			default: state_d = mcaoa_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready          = 1'b0;
		m_tvalid          = 1'b0;
		div_start         = 1'b0;
		bank_ctl.acc_en    = 1'b0;
		bank_ctl.clear_all = 1'b0;
		bank_ctl.addr      = idx_q;
		bank_ctl.sample    = sample_q;
		case (state_q)
			mcaoa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			mcaoa_pkg::ST_ACC: begin
				bank_ctl.addr   = slot_q;
				bank_ctl.acc_en = in_range;
			end
			mcaoa_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
			end
			mcaoa_pkg::ST_DIV_WAIT: begin
			end
			mcaoa_pkg::ST_EMIT: begin
				m_tvalid           = 1'b1;
				bank_ctl.clear_all = m_tready && last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcaoa_pkg::ST_IDLE;
			cc_q    <= mcaoa_pkg::CC_RESET;
			spa_q   <= mcaoa_pkg::SPA_RESET;
			sweep_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_xfer && cfg_index == mcaoa_pkg::REG_CHANNEL_COUNT) begin
				cc_q <= cfg_data[mcaoa_pkg::CC_W-1:0];
			end
			if (cfg_xfer && cfg_index == mcaoa_pkg::REG_SAMPLES_PER_AVERAGE) begin
				spa_q <= cfg_data;
			end
			if (state_q == mcaoa_pkg::ST_ACC && sweep_end) begin
				sweep_q <= fire ? '0 : sweep_inc;
			end
			if (state_q == mcaoa_pkg::ST_ACC) begin
				idx_q <= '0;
			end else if (m_xfer) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// The quotient is reduced by four and held to ten bits.
	assign q_shift = quotient[mcaoa_pkg::SUM_W-1:2];

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			slot_q   <= s_tdata[mcaoa_pkg::SLOT_W-1:0];
			sample_q <= s_tdata[mcaoa_pkg::SLOT_W +: mcaoa_pkg::SAMPLE_W];
		end
		if (state_q == mcaoa_pkg::ST_DIV_WAIT && div_done) begin
			out_slot_q <= idx_q;
			avg_q      <= (|q_shift[mcaoa_pkg::SUM_W-3:mcaoa_pkg::AVG_W]) ? mcaoa_pkg::AVG_MAX
			              : q_shift[mcaoa_pkg::AVG_W-1:0];
			last_q     <= ({1'b0, idx_q} == nch_m1);
		end
	end

	assign m_tdata = {2'b00, avg_q, out_slot_q};
	assign m_tlast = last_q;

	mcaoa_sum_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bank_ctl),
		.rd_sum (rd_sum)
	);

	mcaoa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_sum),
		.divisor  (ns),
		.done     (div_done),
		.quotient (quotient)
	);

	`MCAOA_NEVER(a_no_input_while_emitting, s_tready && m_tvalid, "input taken during emission")
	`MCAOA_ASSERT(a_emit_slot_in_range, m_tvalid |-> ({1'b0, out_slot_q} < nch), "emitted slot out of range")
	`MCAOA_ASSERT(a_final_clears_count, (m_xfer && m_tlast) |=> (sweep_q == '0), "sweep count not cleared")
	`MCAOA_ASSERT(a_final_returns_idle, (m_xfer && m_tlast) |=> s_tready, "not idle after final result")

endmodule
